/* rtl/ows_pkg.sv */
// ----------------------------------------------------------------------------
// ows_pkg
// Shared types, timing constants and the phase length lookup for the
// one-wire slot master.
// ----------------------------------------------------------------------------
package ows_pkg;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_RESET = 3'd1,
      OP_WBIT  = 3'd2,
      OP_RBIT  = 3'd3,
      OP_WBYTE = 3'd4,
      OP_RBYTE = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      PH_LOW     = 2'd0,
      PH_WAIT    = 2'd1,
      PH_RECOVER = 2'd2
   } phase_type;

   localparam int unsigned TicksWidth = 9;
   localparam int unsigned DataWidth  = 8;
   localparam int unsigned ReqDataWidth = 16;
   localparam int unsigned RspDataWidth = 16;

   typedef logic [TicksWidth-1:0] ticks_type;

   localparam ticks_type STD_RESET_LOW     = 9'd480;
   localparam ticks_type STD_RESET_WAIT    = 9'd70;
   localparam ticks_type STD_RESET_RECOVER = 9'd410;
   localparam ticks_type STD_W1_LOW        = 9'd6;
   localparam ticks_type STD_W1_RECOVER    = 9'd64;
   localparam ticks_type STD_W0_LOW        = 9'd60;
   localparam ticks_type STD_W0_RECOVER    = 9'd10;
   localparam ticks_type STD_RD_LOW        = 9'd6;
   localparam ticks_type STD_RD_WAIT       = 9'd9;
   localparam ticks_type STD_RD_RECOVER    = 9'd55;
   localparam ticks_type OD_RESET_LOW      = 9'd70;
   localparam ticks_type OD_RESET_WAIT     = 9'd8;
   localparam ticks_type OD_RESET_RECOVER  = 9'd402;
   localparam ticks_type OD_W1_LOW         = 9'd1;
   localparam ticks_type OD_W1_RECOVER     = 9'd7;
   localparam ticks_type OD_W0_LOW         = 9'd7;
   localparam ticks_type OD_W0_RECOVER     = 9'd2;
   localparam ticks_type OD_RD_LOW         = 9'd1;
   localparam ticks_type OD_RD_WAIT        = 9'd7;
   localparam ticks_type OD_RD_RECOVER     = 9'd13;

   typedef struct packed {
      op_type               op;
      logic                 line_level;
      logic [DataWidth-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic                 rejected;
      logic [DataWidth-1:0] data_out;
      logic                 done_res;
      logic                 busy_res;
      logic                 drive_low;
   } rsp_item_type;

   function automatic ticks_type phase_len(op_type cmd, phase_type ph, logic bit_val,
                                           logic od);
      ticks_type len;
      unique case (cmd)
         OP_RESET: begin
            unique case (ph)
               PH_LOW:  len = od ? OD_RESET_LOW  : STD_RESET_LOW;
               PH_WAIT: len = od ? OD_RESET_WAIT : STD_RESET_WAIT;
               default: len = od ? OD_RESET_RECOVER : STD_RESET_RECOVER;
            endcase
         end
         OP_WBIT, OP_WBYTE: begin
            if (bit_val) begin
               len = (ph == PH_LOW) ? (od ? OD_W1_LOW : STD_W1_LOW)
                                    : (od ? OD_W1_RECOVER : STD_W1_RECOVER);
            end else begin
               len = (ph == PH_LOW) ? (od ? OD_W0_LOW : STD_W0_LOW)
                                    : (od ? OD_W0_RECOVER : STD_W0_RECOVER);
            end
         end
         default: begin
            unique case (ph)
               PH_LOW:  len = od ? OD_RD_LOW  : STD_RD_LOW;
               PH_WAIT: len = od ? OD_RD_WAIT : STD_RD_WAIT;
               default: len = od ? OD_RD_RECOVER : STD_RD_RECOVER;
            endcase
         end
      endcase
      return len;
   endfunction

endpackage

/* rtl/onewire_slot_master.sv */
// ----------------------------------------------------------------------------
// onewire_slot_master
// 1-Wire bus master slot generator driven by one-microsecond tick requests.
// ----------------------------------------------------------------------------
// Path: an accepted request is taken into the request register, then into the
//   response register once the response side is not stalled.
// Throughput: one request per cycle unless stalled; the sequencer step is
//   one counter decrement or phase table lookup between the two registers.
// Reset: synchronous; clears the sequencer to idle, bus released, both
//   pipeline registers empty, overdrive off.
// ----------------------------------------------------------------------------
module onewire_slot_master
   import ows_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] line_level, [8:1] write_data, [15:9] zero pad
   input  logic [ReqDataWidth-1:0] req_tdata,
   // [2:0] operation
   input  logic [2:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [0] drive_low, [1] busy_res, [2] done_res, [10:3] data_out, [11] rejected
   output logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data
);

   logic         overdrive_ff;
   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         can_load;
   logic         advance;
   rsp_item_type rsp_next;
   rsp_item_type rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         overdrive_ff <= 1'b0;
      end else if (csr_wr_en) begin
         overdrive_ff <= csr_wr_data;
      end
   end

   assign req_item.op         = op_type'(req_tuser);
   assign req_item.line_level = req_tdata[0];
   assign req_item.write_data = req_tdata[DataWidth:1];

   assign advance = item_valid && can_load;

   ows_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ows_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .overdrive (overdrive_ff),
      .rsp       (rsp_next)
   );

   ows_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .rsp_in     (rsp_next),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {{(RspDataWidth-$bits(rsp_item_type)){1'b0}}, rsp_item};

endmodule

/* rtl/ows_in_stage.sv */
// ----------------------------------------------------------------------------
// ows_in_stage
// Request register: holds one request until the engine consumes it.
// ----------------------------------------------------------------------------
module ows_in_stage
   import ows_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/ows_engine.sv */
// ----------------------------------------------------------------------------
// ows_engine
// Slot sequencer: command, phase, tick counter, bit position and shift data.
// Advances once per consumed request and forms that request's response.
// ----------------------------------------------------------------------------
module ows_engine
   import ows_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  logic         overdrive,
   output rsp_item_type rsp
);

   // OP_TICK in cmd_ff means idle
   op_type               cmd_ff, cmd_in;
   phase_type            phase_ff, phase_in;
   ticks_type            ticks_ff, ticks_in;
   logic [2:0]           bitpos_ff, bitpos_in;
   logic [DataWidth-1:0] shift_ff, shift_in;
   logic                 drive_ff, drive_in;

   logic busy;
   logic is_write;
   logic is_byte;
   logic last_slot;
   logic phase_end;

   assign busy      = (cmd_ff != OP_TICK);
   assign is_write  = (cmd_ff == OP_WBIT) || (cmd_ff == OP_WBYTE);
   assign is_byte   = (cmd_ff == OP_WBYTE) || (cmd_ff == OP_RBYTE);
   assign last_slot = !is_byte || (bitpos_ff == 3'd7);
   assign phase_end = (ticks_ff <= ticks_type'(1));

   // next state
   always_comb begin
      cmd_in    = cmd_ff;
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      bitpos_in = bitpos_ff;
      shift_in  = shift_ff;
      drive_in  = drive_ff;
      unique case (item.op)
         OP_RESET, OP_WBIT, OP_RBIT, OP_WBYTE, OP_RBYTE: begin
            if (!busy) begin
               cmd_in    = item.op;
               bitpos_in = 3'd0;
               if (item.op == OP_WBIT) begin
                  shift_in = {{(DataWidth-1){1'b0}}, item.write_data[0]};
               end else if (item.op == OP_WBYTE) begin
                  shift_in = item.write_data;
               end else begin
                  shift_in = '0;
               end
               phase_in = PH_LOW;
               ticks_in = phase_len(item.op, PH_LOW, shift_in[0], overdrive);
               drive_in = 1'b1;
            end
         end
         OP_TICK: begin
            if (busy) begin
               if (!phase_end) begin
                  ticks_in = ticks_ff - ticks_type'(1);
               end else begin
                  unique case (phase_ff)
                     PH_LOW: begin
                        drive_in = 1'b0;
                        phase_in = is_write ? PH_RECOVER : PH_WAIT;
                        ticks_in = phase_len(cmd_ff, phase_in, shift_ff[0], overdrive);
                     end
                     PH_WAIT: begin
                        if (cmd_ff == OP_RESET) begin
                           shift_in = {{(DataWidth-1){1'b0}}, !item.line_level};
                        end else if (cmd_ff == OP_RBIT) begin
                           shift_in = {{(DataWidth-1){1'b0}}, item.line_level};
                        end else begin
                           shift_in = {item.line_level, shift_ff[DataWidth-1:1]};
                        end
                        phase_in = PH_RECOVER;
                        ticks_in = phase_len(cmd_ff, PH_RECOVER, shift_ff[0], overdrive);
                     end
                     default: begin
                        if (cmd_ff == OP_WBYTE) begin
                           shift_in = {1'b0, shift_ff[DataWidth-1:1]};
                        end
                        if (is_byte) begin
                           bitpos_in = bitpos_ff + 3'd1;
                        end
                        if (last_slot) begin
                           cmd_in   = OP_TICK;
                           phase_in = PH_LOW;
                           ticks_in = '0;
                           drive_in = 1'b0;
                        end else begin
                           phase_in = PH_LOW;
                           ticks_in = phase_len(cmd_ff, PH_LOW, shift_in[0], overdrive);
                           drive_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response
   always_comb begin
      rsp.drive_low = drive_in;
      rsp.busy_res  = (cmd_in != OP_TICK);
      rsp.rejected  = busy && (item.op == OP_RESET || item.op == OP_WBIT ||
                               item.op == OP_RBIT || item.op == OP_WBYTE ||
                               item.op == OP_RBYTE);
      rsp.done_res  = busy && (item.op == OP_TICK) && phase_end &&
                      (phase_ff != PH_LOW) && (phase_ff != PH_WAIT) && last_slot;
      rsp.data_out  = '0;
      if (rsp.done_res) begin
         unique case (cmd_ff)
            OP_RESET, OP_RBIT: rsp.data_out = {{(DataWidth-1){1'b0}}, shift_ff[0]};
            OP_RBYTE:          rsp.data_out = shift_ff;
            default:           rsp.data_out = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff    <= OP_TICK;
         phase_ff  <= PH_LOW;
         ticks_ff  <= '0;
         bitpos_ff <= '0;
         shift_ff  <= '0;
         drive_ff  <= 1'b0;
      end else if (advance) begin
         cmd_ff    <= cmd_in;
         phase_ff  <= phase_in;
         ticks_ff  <= ticks_in;
         bitpos_ff <= bitpos_in;
         shift_ff  <= shift_in;
         drive_ff  <= drive_in;
      end
   end

endmodule

/* rtl/ows_out_stage.sv */
// ----------------------------------------------------------------------------
// ows_out_stage
// Response register: holds one response until the sink takes it.
// ----------------------------------------------------------------------------
module ows_out_stage
   import ows_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type rsp_in,
   output logic         can_load,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

/* rtl/ows_checker.sv */
// ----------------------------------------------------------------------------
// ows_checker
// Port-level checks on the slot master's response stream.
// ----------------------------------------------------------------------------
module ows_checker
   import ows_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   // done ends the sequence
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("done with busy still set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> !rsp_tdata[2] && rsp_tdata[1])
      else $error("rejected request not while busy, or with done");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("bus driven low while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[10:3] == 8'd0)
      else $error("data nonzero without done");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind onewire_slot_master ows_checker u_ows_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/tb_onewire_slot_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onewire_slot_master
// Self-checking bench for the one-wire slot master. Requests (ticks with a
// sampled line level, and reset/bit/byte commands) are streamed in with
// random bursts and gaps, and responses are drained against a random stall
// pattern. A scoreboard tracks the slot sequencer in step with every
// accepted request and checks each response field by field. The overdrive
// setting is switched between standard and overdrive timing, once while a
// byte read is still in progress.
// ----------------------------------------------------------------------------
module tb_onewire_slot_master;
   import ows_pkg::*;

   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   typedef enum int {LVL_LOW, LVL_HIGH, LVL_RANDOM} level_mode_type;
   typedef enum int {RX_STEADY, RX_COIN, RX_MOSTLY, RX_CADENCE} rx_mode_type;

   class slot_scoreboard;
      bit           od;
      op_type       active;
      phase_type    phase;
      ticks_type    ticks_left;
      logic [2:0]   bit_pos;
      logic [7:0]   shifter;
      logic         drive;
      rsp_item_type expected_q[$];
      int           fails;
      int           rejects;
      int           presences;
      int           done_by_op[6];

      function new();
         od         = 1'b0;
         active     = OP_TICK;
         phase      = PH_LOW;
         ticks_left = '0;
         bit_pos    = '0;
         shifter    = '0;
         drive      = 1'b0;
         fails      = 0;
         rejects    = 0;
         presences  = 0;
         foreach (done_by_op[i]) done_by_op[i] = 0;
      endfunction

      function bit busy();
         return active != OP_TICK;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void set_overdrive(bit v);
         od = v;
      endfunction

      // phase length for the active command at the current speed
      function ticks_type slot_len(phase_type ph, logic bitv);
         if (active == OP_RESET) begin
            if (ph == PH_LOW) return od ? OD_RESET_LOW : STD_RESET_LOW;
            if (ph == PH_WAIT) return od ? OD_RESET_WAIT : STD_RESET_WAIT;
            return od ? OD_RESET_RECOVER : STD_RESET_RECOVER;
         end
         if (active == OP_WBIT || active == OP_WBYTE) begin
            if (ph == PH_LOW) begin
               if (bitv) return od ? OD_W1_LOW : STD_W1_LOW;
               return od ? OD_W0_LOW : STD_W0_LOW;
            end
            if (bitv) return od ? OD_W1_RECOVER : STD_W1_RECOVER;
            return od ? OD_W0_RECOVER : STD_W0_RECOVER;
         end
         if (ph == PH_LOW) return od ? OD_RD_LOW : STD_RD_LOW;
         if (ph == PH_WAIT) return od ? OD_RD_WAIT : STD_RD_WAIT;
         return od ? OD_RD_RECOVER : STD_RD_RECOVER;
      endfunction

      function void begin_slot();
         phase      = PH_LOW;
         ticks_left = slot_len(PH_LOW, shifter[0]);
         drive      = 1'b1;
      endfunction

      function void note_request(logic [2:0] op, logic level, logic [7:0] wdata);
         rsp_item_type r;
         bit           was_busy;
         bit           is_write;
         bit           last;
         logic         bitv;
         r        = '0;
         was_busy = busy();
         if (op >= OP_RESET && op <= OP_RBYTE) begin
            if (was_busy) begin
               r.rejected = 1'b1;
               rejects++;
            end else begin
               active  = op_type'(op);
               bit_pos = '0;
               if (active == OP_WBIT) shifter = {7'b0, wdata[0]};
               else if (active == OP_WBYTE) shifter = wdata;
               else shifter = '0;
               begin_slot();
            end
         end else if (op == OP_TICK && was_busy) begin
            if (ticks_left > 1) begin
               ticks_left = ticks_left - 1'b1;
            end else begin
               is_write = (active == OP_WBIT || active == OP_WBYTE);
               bitv     = shifter[0];
               if (phase == PH_LOW) begin
                  drive      = 1'b0;
                  phase      = is_write ? PH_RECOVER : PH_WAIT;
                  ticks_left = slot_len(phase, bitv);
               end else if (phase == PH_WAIT) begin
                  // line sampled on the tick that closes the wait phase
                  if (active == OP_RESET) shifter = {7'b0, ~level};
                  else if (active == OP_RBIT) shifter = {7'b0, level};
                  else shifter = {level, shifter[7:1]};
                  phase      = PH_RECOVER;
                  ticks_left = slot_len(PH_RECOVER, bitv);
               end else begin
                  last = 1'b1;
                  if (active == OP_WBYTE || active == OP_RBYTE) begin
                     if (active == OP_WBYTE) shifter = shifter >> 1;
                     bit_pos = bit_pos + 1'b1;
                     last    = (bit_pos == 3'd0);
                  end
                  if (last) begin
                     r.done_res = 1'b1;
                     if (active == OP_RESET || active == OP_RBIT) r.data_out = {7'b0, shifter[0]};
                     else if (active == OP_RBYTE) r.data_out = shifter;
                     if (active == OP_RESET && shifter[0]) presences++;
                     done_by_op[int'(active)]++;
                     active     = OP_TICK;
                     phase      = PH_LOW;
                     ticks_left = '0;
                     drive      = 1'b0;
                  end else begin
                     begin_slot();
                  end
               end
            end
         end
         r.drive_low = drive;
         r.busy_res  = busy();
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [RspDataWidth-1:0] word);
         rsp_item_type got;
         rsp_item_type want;
         got = rsp_item_type'(word[11:0]);
         if (expected_q.size() == 0) begin
            $display("%t: unexpected response %h", $realtime, word);
            fails++;
            return;
         end
         want = expected_q.pop_front();
         if (got.drive_low !== want.drive_low) begin
            $display("%t: drive_low expected %0d actual %0d", $realtime, want.drive_low,
                     got.drive_low);
            fails++;
         end
         if (got.busy_res !== want.busy_res) begin
            $display("%t: busy_res expected %0d actual %0d", $realtime, want.busy_res,
                     got.busy_res);
            fails++;
         end
         if (got.done_res !== want.done_res) begin
            $display("%t: done_res expected %0d actual %0d", $realtime, want.done_res,
                     got.done_res);
            fails++;
         end
         if (got.data_out !== want.data_out) begin
            $display("%t: data_out expected %h actual %h", $realtime, want.data_out,
                     got.data_out);
            fails++;
         end
         if (got.rejected !== want.rejected) begin
            $display("%t: rejected expected %0d actual %0d", $realtime, want.rejected,
                     got.rejected);
            fails++;
         end
         if (word[RspDataWidth-1:12] !== '0) begin
            $display("%t: pad bits expected 0 actual %h", $realtime, word[RspDataWidth-1:12]);
            fails++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic [2:0]              req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_wr_en = 1'b0;
   logic                    csr_wr_data = 1'b0;

   slot_scoreboard sb;
   int             sent = 0;
   int             burst_left = 0;
   bit             sender_steady = 1'b0;
   bit             hold_request = 1'b0;

   onewire_slot_master dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) sb.check_response(rsp_tdata);
   end

   // response side: stall pattern plus one long counted hold-off on request
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          cadence;
      mode      = RX_STEADY;
      mode_left = 0;
      hold_left = 0;
      cadence   = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
               default:   rsp_tready <= ((cadence % 5) < 3);
            endcase
            cadence++;
         end
      end
   end

   task automatic pause(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_req(input logic [2:0] op, input logic level, input logic [7:0] wdata);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, wdata, level};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, level, wdata);
      sent++;
      if (!sender_steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
         end
      end
   endtask

   // stop sending and let every pending response come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_overdrive(input bit v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      sb.set_overdrive(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic pick_level(level_mode_type mode);
      if (mode == LVL_LOW) return 1'b0;
      if (mode == LVL_HIGH) return 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic run_ticks(input level_mode_type mode, input int limit);
      int n;
      n = 0;
      while (sb.busy() && n < limit) begin
         send_req(OP_TICK, pick_level(mode), 8'($urandom_range(0, 255)));
         n++;
      end
   endtask

   task automatic run_command(input op_type op, input logic [7:0] wdata,
                              input level_mode_type mode);
      send_req(op, 1'($urandom_range(0, 1)), wdata);
      run_ticks(mode, 1 << 20);
   endtask

   // one command run to completion, with rejected commands and spare codes mixed in
   task automatic random_sequence();
      int             pick;
      int             r;
      level_mode_type mode;
      logic [2:0]     op;
      logic [7:0]     wdata;
      pick = $urandom_range(0, 19);
      if (pick == 0) op = OP_RESET;
      else if (pick <= 2) op = $urandom_range(0, 1) ? OP_WBYTE : OP_RBYTE;
      else op = $urandom_range(0, 1) ? OP_WBIT : OP_RBIT;
      r = $urandom_range(0, 5);
      mode = (r == 0) ? LVL_LOW : (r == 1) ? LVL_HIGH : LVL_RANDOM;
      wdata = 8'($urandom_range(0, 255));
      send_req(op, 1'($urandom_range(0, 1)), wdata);
      while (sb.busy()) begin
         r = $urandom_range(0, 99);
         if (r < 4)
            send_req(3'($urandom_range(1, 5)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
         else if (r < 7)
            send_req($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
         else send_req(OP_TICK, pick_level(mode), 8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 3)) begin
         r = $urandom_range(0, 2);
         op = (r == 0) ? OP_TICK : (r == 1) ? OP_SPARE6 : OP_SPARE7;
         send_req(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle ticks and spare codes while idle
      send_req(OP_TICK, 1'b0, 8'h00);
      send_req(OP_TICK, 1'b1, 8'hFF);
      send_req(OP_SPARE6, 1'b1, 8'hFF);
      send_req(OP_SPARE7, 1'b0, 8'h00);

      // every command and the spare codes while busy
      send_req(OP_WBIT, 1'b0, 8'hFE);
      for (int c = OP_RESET; c <= OP_RBYTE; c++) send_req(3'(c), 1'b1, 8'hFF);
      send_req(OP_SPARE6, 1'b0, 8'h00);
      send_req(OP_SPARE7, 1'b1, 8'hFF);
      run_ticks(LVL_RANDOM, 1 << 20);

      run_command(OP_WBIT, 8'h01, LVL_RANDOM);
      run_command(OP_RBIT, 8'hFF, LVL_LOW);
      run_command(OP_RBIT, 8'h00, LVL_HIGH);

      // speed change in the middle of a byte read
      send_req(OP_RBYTE, 1'b0, 8'hA5);
      run_ticks(LVL_RANDOM, 25);
      write_overdrive(1'b1);
      run_ticks(LVL_RANDOM, 1 << 20);
      run_command(OP_WBYTE, 8'h00, LVL_RANDOM);
      run_command(OP_WBYTE, 8'hFF, LVL_RANDOM);
      run_command(OP_RESET, 8'h00, LVL_LOW);
      run_command(OP_RBYTE, 8'h5A, LVL_LOW);

      // long response hold-off while requests keep streaming in
      sender_steady = 1'b1;
      hold_request  = 1'b1;
      begin
         int mark;
         mark = sent;
         while (sent < mark + 80) random_sequence();
      end
      sender_steady = 1'b0;
      while (sent < 1450) random_sequence();

      write_overdrive(1'b0);
      while (sent < 1750) random_sequence();
      write_overdrive(1'b1);
      while (sent < 1900) random_sequence();
      drain();
      repeat (6) @(posedge clock);

      if (sb.pending() != 0) begin
         $display("%t: %0d responses never arrived", $realtime, sb.pending());
         sb.fails++;
      end
      $display("%0d requests at both speeds: %0d resets (%0d with presence), %0d bit writes,",
               sent, sb.done_by_op[OP_RESET], sb.presences, sb.done_by_op[OP_WBIT]);
      $display("%0d bit reads, %0d byte writes, %0d byte reads, %0d rejected, %0d mismatches",
               sb.done_by_op[OP_RBIT], sb.done_by_op[OP_WBYTE], sb.done_by_op[OP_RBYTE],
               sb.rejects, sb.fails);
      if (sb.fails == 0) begin
         $display("onewire_slot_master regression: pass");
      end else begin
         $display("onewire_slot_master regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%t: timeout", $realtime);
      $display("onewire_slot_master regression: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/ows_pkg.sv
rtl/ows_in_stage.sv
rtl/ows_engine.sv
rtl/ows_out_stage.sv
rtl/onewire_slot_master.sv
rtl/ows_checker.sv
tb/tb_onewire_slot_master.sv
